// ----- rtl/tca_pkg.sv -----
// Shared constants, widths and types for the triangle circle area pipeline.
`timescale 1ns / 1ps
package tca_pkg;

   localparam int FRAC_BITS = 8;
   localparam int SIDE_W    = 24;
   localparam int AREA_W    = 48;
   localparam int STATUS_W  = 2;

   // pi scaled by 2^60
   localparam int PI_W = 62;
   localparam logic [PI_W-1:0] PI60 = 62'h3243F6A8885A308D;

   localparam int SUM_W  = SIDE_W + 2;       // perimeter sum and signed legs
   localparam int LEG_W  = SIDE_W + 1;       // legs once known positive
   localparam int UV_W   = 2 * LEG_W;
   localparam int T_W    = UV_W + LEG_W;
   localparam int AB_W   = 2 * SIDE_W;
   localparam int ABC_W  = AB_W + SIDE_W;
   localparam int P_W    = T_W + SUM_W;
   localparam int ABC2_W = 2 * ABC_W;
   localparam int N1_W   = T_W + PI_W;
   localparam int N2_W   = ABC2_W + PI_W;

   // digit chains for square root and both quotients share one length
   localparam int CHAIN_LEN = 50;

   localparam int Z1_SHIFT = FRAC_BITS + 62;
   localparam int Z2_SHIFT = FRAC_BITS + 60;
   localparam int Z1_W     = N1_W + 1 - Z1_SHIFT;
   localparam int Z2_W     = N2_W + 1 - Z2_SHIFT;

   localparam int MUL_STAGES_A = 4;
   localparam int MUL_STAGES_B = 9;

   localparam int LATENCY = 2 + MUL_STAGES_A + 2 * MUL_STAGES_B + 2 + CHAIN_LEN + 2;

   localparam logic [AREA_W-1:0] OUT_MAX = '1;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SAT  = 2'd3;

   typedef struct packed {
      logic [AREA_W-1:0]   outer_gap_area;
      logic [AREA_W-1:0]   inner_gap_area;
      logic [AREA_W-1:0]   incircle_area;
      logic [STATUS_W-1:0] status;
   } tca_result_type;

endpackage

// ----- rtl/tca_mul.sv -----
// Pipelined multiplier: a row of cells, each adding one digit's partial product.
`timescale 1ns / 1ps
module tca_mul #(
   parameter int WA  = 8,
   parameter int WB  = 8,
   parameter int NST = 2,
   parameter int WS  = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   input  logic [WS-1:0]    side_i,
   output logic [WA+WB-1:0] p,
   output logic [WS-1:0]    side_o
);
   localparam int DIG = (WB + NST - 1) / NST;
   localparam int WBP = DIG * NST;
   localparam int WP  = WA + WB;

   logic [WP-1:0]  acc_ff  [NST];
   logic [WA-1:0]  a_ff    [NST];
   logic [WBP-1:0] b_ff    [NST];
   logic [WS-1:0]  side_ff [NST];

   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_cell
         logic [WP-1:0]     acc_prev;
         logic [WP-1:0]     acc_in;
         logic [WA-1:0]     a_prev;
         logic [WBP-1:0]    b_prev;
         logic [WS-1:0]     side_prev;
         logic [WA+DIG-1:0] pp;

         if (k == 0) begin : g_head
            assign acc_prev  = '0;
            assign a_prev    = a;
            assign b_prev    = WBP'(b);
            assign side_prev = side_i;
         end else begin : g_link
            assign acc_prev  = acc_ff[k-1];
            assign a_prev    = a_ff[k-1];
            assign b_prev    = b_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         // low digit of the remaining multiplier, weighted by its place
         assign pp     = (WA+DIG)'(a_prev) * (WA+DIG)'(b_prev[DIG-1:0]);
         assign acc_in = acc_prev + (WP'(pp) << (k * DIG));

         always_ff @(posedge clock) begin
            if (en) begin
               acc_ff[k]  <= acc_in;
               a_ff[k]    <= a_prev;
               b_ff[k]    <= b_prev >> DIG;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign p      = acc_ff[NST-1];
   assign side_o = side_ff[NST-1];

endmodule

// ----- rtl/tca_sqrt.sv -----
// Integer square root: a row of cells, each settling one root bit.
`timescale 1ns / 1ps
module tca_sqrt #(
   parameter int WR = 50,
   parameter int WS = 1
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*WR-1:0] op,
   input  logic [WS-1:0]   side_i,
   output logic [WR-1:0]   root,
   output logic [WS-1:0]   side_o
);
   localparam int WM = WR + 2;

   logic [WM-1:0]   rem_ff  [WR];
   logic [WR-1:0]   root_ff [WR];
   logic [2*WR-1:0] op_ff   [WR];
   logic [WS-1:0]   side_ff [WR];

   genvar k;
   generate
      for (k = 0; k < WR; k++) begin : g_cell
         logic [WM-1:0]   rem_prev;
         logic [WR-1:0]   root_prev;
         logic [2*WR-1:0] op_prev;
         logic [WS-1:0]   side_prev;
         logic [WM+1:0]   r2;
         logic [WM+1:0]   trial;
         logic [WM+1:0]   diff;
         logic            ge;
         logic [WM-1:0]   rem_in;

         if (k == 0) begin : g_head
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign op_prev   = op;
            assign side_prev = side_i;
         end else begin : g_link
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
            assign op_prev   = op_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         // bring down two bits, try 4*root+1
         assign r2     = {rem_prev, op_prev[2*WR-1 -: 2]};
         assign trial  = (WM+2)'({root_prev, 2'b01});
         assign ge     = (r2 >= trial);
         assign diff   = r2 - trial;
         assign rem_in = ge ? WM'(diff) : WM'(r2);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= {root_prev[WR-2:0], ge};
               op_ff[k]   <= op_prev << 2;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign root   = root_ff[WR-1];
   assign side_o = side_ff[WR-1];

endmodule

// ----- rtl/tca_div.sv -----
// Restoring divider: a row of cells, each settling one quotient bit.
`timescale 1ns / 1ps
module tca_div #(
   parameter int WD = 8,
   parameter int NQ = 8,
   parameter int WS = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [WD-1:0] rem_i,
   input  logic [NQ-1:0] lo_i,
   input  logic [WD-1:0] den,
   input  logic [WS-1:0] side_i,
   output logic [NQ-1:0] quo,
   output logic [WS-1:0] side_o
);
   logic [WD-1:0] rem_ff  [NQ];
   logic [NQ-1:0] lo_ff   [NQ];
   logic [WD-1:0] den_ff  [NQ];
   logic [NQ-1:0] quo_ff  [NQ];
   logic [WS-1:0] side_ff [NQ];

   genvar k;
   generate
      for (k = 0; k < NQ; k++) begin : g_cell
         logic [WD-1:0] rem_prev;
         logic [NQ-1:0] lo_prev;
         logic [WD-1:0] den_prev;
         logic [NQ-1:0] quo_prev;
         logic [WS-1:0] side_prev;
         logic [WD:0]   r2;
         logic          ge;
         logic [WD:0]   diff;
         logic [WD-1:0] rem_in;

         if (k == 0) begin : g_head
            assign rem_prev  = rem_i;
            assign lo_prev   = lo_i;
            assign den_prev  = den;
            assign quo_prev  = '0;
            assign side_prev = side_i;
         end else begin : g_link
            assign rem_prev  = rem_ff[k-1];
            assign lo_prev   = lo_ff[k-1];
            assign den_prev  = den_ff[k-1];
            assign quo_prev  = quo_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         assign r2     = {rem_prev, lo_prev[NQ-1]};
         assign ge     = (r2 >= {1'b0, den_prev});
         assign diff   = r2 - {1'b0, den_prev};
         assign rem_in = ge ? WD'(diff) : WD'(r2);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               lo_ff[k]   <= lo_prev << 1;
               den_ff[k]  <= den_prev;
               quo_ff[k]  <= {quo_prev[NQ-2:0], ge};
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign quo    = quo_ff[NQ-1];
   assign side_o = side_ff[NQ-1];

endmodule

// ----- rtl/triangle_circle_areas.sv -----
// Top level: triangle, incircle and circumcircle areas from three side lengths.
`timescale 1ns / 1ps
// Usage
//   Request channel (req_valid / req_stall): three side lengths, unsigned Q16.8.
//   A request is taken at a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall): circumcircle minus triangle area,
//   triangle minus incircle area, incircle area (unsigned Q40.8) and a status
//   code (ok, zero side, not a triangle, outer gap saturated).
// Timing
//   One request per cycle is accepted while req_stall is low. Each request
//   passes a fixed pipeline: side prep, narrow products, three digit-serial
//   multiplier rows (4, 9, 9 cells), a rounding prep pair, 50-cell root and
//   divider rows side by side (one result bit per cell, the bulk of the
//   latency), two finishing stages and the response register.
// Stall
//   A response register plus a one-entry skid register sit at the output.
//   When the receiver stalls and the skid fills, the whole pipeline holds and
//   req_stall goes high until the skid drains.
// Reset
//   Synchronous, active high: clears the pipeline valid bits, rsp_valid and
//   the skid flag; in-flight requests are dropped.
module triangle_circle_areas (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tca_pkg::SIDE_W-1:0]     req_side_a,
   input  logic [tca_pkg::SIDE_W-1:0]     req_side_b,
   input  logic [tca_pkg::SIDE_W-1:0]     req_side_c,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tca_pkg::AREA_W-1:0]     rsp_outer_gap_area,
   output logic [tca_pkg::AREA_W-1:0]     rsp_inner_gap_area,
   output logic [tca_pkg::AREA_W-1:0]     rsp_incircle_area,
   output logic [tca_pkg::STATUS_W-1:0]   rsp_status
);
   import tca_pkg::*;

   localparam int N2_SIDE_W = P_W + N1_W + SUM_W + 2;
   localparam logic [CHAIN_LEN:0] TRI_HALF = (CHAIN_LEN+1)'(1) << (FRAC_BITS + 1);

   // pipeline advance: hold everything while the skid entry is occupied
   logic en;
   logic out_free;

   logic [LATENCY-1:0] vld_ff;
   logic [LATENCY-1:0] vld_in;

   // ---------------- stage 1: sums, legs, flags ----------------
   logic [SIDE_W-1:0] a1_ff, b1_ff, c1_ff;
   logic [SUM_W-1:0]  sum1_ff, sum1_in;
   logic [LEG_W-1:0]  u1_ff, v1_ff, w1_ff;
   logic              zero1_ff, zero1_in, bad1_ff, bad1_in;
   logic [SUM_W-1:0]  u_raw, v_raw, w_raw;

   always_comb begin
      sum1_in  = SUM_W'(req_side_a) + SUM_W'(req_side_b) + SUM_W'(req_side_c);
      u_raw    = SUM_W'(req_side_b) + SUM_W'(req_side_c) - SUM_W'(req_side_a);
      v_raw    = SUM_W'(req_side_a) + SUM_W'(req_side_c) - SUM_W'(req_side_b);
      w_raw    = SUM_W'(req_side_a) + SUM_W'(req_side_b) - SUM_W'(req_side_c);
      zero1_in = (req_side_a == '0) || (req_side_b == '0) || (req_side_c == '0);
      // a leg is bad when zero or negative (sign bit set)
      bad1_in  = u_raw[SUM_W-1] || (u_raw == '0) || v_raw[SUM_W-1] || (v_raw == '0) ||
                 w_raw[SUM_W-1] || (w_raw == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff    <= req_side_a;
         b1_ff    <= req_side_b;
         c1_ff    <= req_side_c;
         sum1_ff  <= sum1_in;
         u1_ff    <= u_raw[LEG_W-1:0];
         v1_ff    <= v_raw[LEG_W-1:0];
         w1_ff    <= w_raw[LEG_W-1:0];
         zero1_ff <= zero1_in;
         bad1_ff  <= bad1_in;
      end
   end

   // ---------------- stage 2: first narrow products ----------------
   logic [UV_W-1:0]   uv2_ff;
   logic [AB_W-1:0]   ab2_ff;
   logic [LEG_W-1:0]  w2_ff;
   logic [SIDE_W-1:0] c2_ff;
   logic [SUM_W-1:0]  sum2_ff;
   logic              zero2_ff, bad2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         uv2_ff   <= UV_W'(u1_ff) * UV_W'(v1_ff);
         ab2_ff   <= AB_W'(a1_ff) * AB_W'(b1_ff);
         w2_ff    <= w1_ff;
         c2_ff    <= c1_ff;
         sum2_ff  <= sum1_ff;
         zero2_ff <= zero1_ff;
         bad2_ff  <= bad1_ff;
      end
   end

   // ---------------- multiplier rows ----------------
   logic [T_W-1:0]    t3;
   logic [ABC_W-1:0]  abc3;
   logic [SUM_W-1:0]  sum3;
   logic [1:0]        flags3;

   tca_mul #(.WA(UV_W), .WB(LEG_W), .NST(MUL_STAGES_A), .WS(2)) u_mul_t (
      .clock(clock), .en(en), .a(uv2_ff), .b(w2_ff), .side_i({zero2_ff, bad2_ff}),
      .p(t3), .side_o(flags3)
   );

   tca_mul #(.WA(AB_W), .WB(SIDE_W), .NST(MUL_STAGES_A), .WS(SUM_W)) u_mul_abc (
      .clock(clock), .en(en), .a(ab2_ff), .b(c2_ff), .side_i(sum2_ff),
      .p(abc3), .side_o(sum3)
   );

   logic [P_W-1:0]    p4;
   logic [N1_W-1:0]   n1_4;
   logic [ABC2_W-1:0] abc2_4;
   logic [SUM_W-1:0]  sum4;
   logic              zero4, bad4;

   tca_mul #(.WA(T_W), .WB(SUM_W), .NST(MUL_STAGES_B), .WS(1)) u_mul_p (
      .clock(clock), .en(en), .a(t3), .b(sum3), .side_i(flags3[1]),
      .p(p4), .side_o(zero4)
   );

   tca_mul #(.WA(T_W), .WB(PI_W), .NST(MUL_STAGES_B), .WS(1)) u_mul_n1 (
      .clock(clock), .en(en), .a(t3), .b(PI60), .side_i(flags3[0]),
      .p(n1_4), .side_o(bad4)
   );

   tca_mul #(.WA(ABC_W), .WB(ABC_W), .NST(MUL_STAGES_B), .WS(SUM_W)) u_mul_sq (
      .clock(clock), .en(en), .a(abc3), .b(abc3), .side_i(sum3),
      .p(abc2_4), .side_o(sum4)
   );

   logic [N2_W-1:0]      n2_5;
   logic [N2_SIDE_W-1:0] side5;
   logic [P_W-1:0]       p5;
   logic [N1_W-1:0]      n1_5;
   logic [SUM_W-1:0]     sum5;
   logic                 zero5, bad5;

   tca_mul #(.WA(ABC2_W), .WB(PI_W), .NST(MUL_STAGES_B), .WS(N2_SIDE_W)) u_mul_n2 (
      .clock(clock), .en(en), .a(abc2_4), .b(PI60),
      .side_i({p4, n1_4, sum4, zero4, bad4}),
      .p(n2_5), .side_o(side5)
   );

   assign {p5, n1_5, sum5, zero5, bad5} = side5;

   // ---------------- prep A: add the rounding half, drop the scale ----------------
   logic [Z1_W-1:0]  z1_6_ff, z1_6_in;
   logic [Z2_W-1:0]  z2_6_ff, z2_6_in;
   logic [P_W-1:0]   p6_ff;
   logic [SUM_W-1:0] sum6_ff;
   logic             zero6_ff, bad6_ff;
   logic [N1_W:0]    y1;
   logic [N2_W:0]    y2;

   always_comb begin
      y1      = (N1_W+1)'(n1_5) + ((N1_W+1)'(sum5) << (Z1_SHIFT - 1));
      y2      = (N2_W+1)'(n2_5) + ((N2_W+1)'(p5) << (Z2_SHIFT - 1));
      z1_6_in = Z1_W'(y1 >> Z1_SHIFT);
      z2_6_in = Z2_W'(y2 >> Z2_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z1_6_ff  <= z1_6_in;
         z2_6_ff  <= z2_6_in;
         p6_ff    <= p5;
         sum6_ff  <= sum5;
         zero6_ff <= zero5;
         bad6_ff  <= bad5;
      end
   end

   // ---------------- prep B: circumcircle quotient range check ----------------
   logic [Z1_W-1:0]  z1_7_ff;
   logic [Z2_W-1:0]  z2_7_ff;
   logic [P_W-1:0]   p7_ff;
   logic [SUM_W-1:0] sum7_ff;
   logic             zero7_ff, bad7_ff, ovf7_ff, ovf7_in;

   // quotient would not fit the divider row: saturate downstream
   assign ovf7_in = (P_W'(z2_6_ff >> CHAIN_LEN) >= p6_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         z1_7_ff  <= z1_6_ff;
         z2_7_ff  <= z2_6_ff;
         p7_ff    <= p6_ff;
         sum7_ff  <= sum6_ff;
         zero7_ff <= zero6_ff;
         bad7_ff  <= bad6_ff;
         ovf7_ff  <= ovf7_in;
      end
   end

   // ---------------- root and divider rows, side by side ----------------
   logic [CHAIN_LEN-1:0] m8, q1_8, q2_8;
   logic                 zero8, bad8, ovf8;

   tca_sqrt #(.WR(CHAIN_LEN), .WS(1)) u_sqrt (
      .clock(clock), .en(en), .op(p7_ff[2*CHAIN_LEN-1:0]), .side_i(zero7_ff),
      .root(m8), .side_o(zero8)
   );

   tca_div #(.WD(SUM_W), .NQ(CHAIN_LEN), .WS(1)) u_div_in (
      .clock(clock), .en(en),
      .rem_i(SUM_W'(z1_7_ff >> CHAIN_LEN)), .lo_i(z1_7_ff[CHAIN_LEN-1:0]),
      .den(sum7_ff), .side_i(bad7_ff),
      .quo(q1_8), .side_o(bad8)
   );

   tca_div #(.WD(P_W), .NQ(CHAIN_LEN), .WS(1)) u_div_circ (
      .clock(clock), .en(en),
      .rem_i(P_W'(z2_7_ff >> CHAIN_LEN)), .lo_i(z2_7_ff[CHAIN_LEN-1:0]),
      .den(p7_ff), .side_i(ovf7_ff),
      .quo(q2_8), .side_o(ovf8)
   );

   // ---------------- finish A: round the triangle area ----------------
   logic [CHAIN_LEN-1:0] tri9_ff, tri9_in, q1_9_ff, q2_9_ff;
   logic                 zero9_ff, bad9_ff, ovf9_ff;

   assign tri9_in = CHAIN_LEN'(((CHAIN_LEN+1)'(m8) + TRI_HALF) >> (FRAC_BITS + 2));

   always_ff @(posedge clock) begin
      if (en) begin
         tri9_ff  <= tri9_in;
         q1_9_ff  <= q1_8;
         q2_9_ff  <= q2_8;
         zero9_ff <= zero8;
         bad9_ff  <= bad8;
         ovf9_ff  <= ovf8;
      end
   end

   // ---------------- finish B: gaps, saturation, status ----------------
   tca_result_type       res_ff, res_in;
   logic [CHAIN_LEN-1:0] inner_w, gap_w;
   logic                 circ_ge;

   always_comb begin
      res_in  = '0;
      circ_ge = (q2_9_ff >= tri9_ff);
      inner_w = (q1_9_ff <= tri9_ff) ? (tri9_ff - q1_9_ff) : '0;
      gap_w   = q2_9_ff - tri9_ff;
      if (zero9_ff) begin
         res_in.status = ST_ZERO;
      end else if (bad9_ff) begin
         res_in.status = ST_BAD;
      end else begin
         res_in.incircle_area  = AREA_W'(q1_9_ff);
         res_in.inner_gap_area = AREA_W'(inner_w);
         res_in.status         = ST_OK;
         if (ovf9_ff || (circ_ge && (|gap_w[CHAIN_LEN-1:AREA_W]))) begin
            res_in.outer_gap_area = OUT_MAX;
            res_in.status         = ST_SAT;
         end else if (circ_ge) begin
            res_in.outer_gap_area = AREA_W'(gap_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   // ---------------- valid tracking ----------------
   assign vld_in = {vld_ff[LATENCY-2:0], req_valid};

   // ---------------- output register and skid entry ----------------
   logic           rsp_valid_ff, skid_v_ff;
   tca_result_type out_ff, skid_ff;
   logic           pv;

   assign en        = !skid_v_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pv        = vld_ff[LATENCY-1];
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
            // final stage result moves on: to the output if free, else park it
            if (out_free) begin
               rsp_valid_ff <= pv;
            end else if (pv) begin
               skid_v_ff <= 1'b1;
            end
         end else if (out_free) begin
            // drain the parked result; the pipeline resumes next cycle
            rsp_valid_ff <= 1'b1;
            skid_v_ff    <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (out_free) begin
            out_ff <= res_ff;
         end else if (pv) begin
            skid_ff <= res_ff;
         end
      end else if (out_free) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outer_gap_area = out_ff.outer_gap_area;
   assign rsp_inner_gap_area = out_ff.inner_gap_area;
   assign rsp_incircle_area  = out_ff.incircle_area;
   assign rsp_status         = out_ff.status;

   // ---------------- assertions ----------------
   a_skid_needs_output : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending response");

   a_skid_fills_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled while the output was free");

   a_zero_side_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ZERO || rsp_status == ST_BAD)) |->
      (rsp_outer_gap_area == '0 && rsp_inner_gap_area == '0 && rsp_incircle_area == '0))
      else $error("rejected triangle carries nonzero areas");

   a_sat_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SAT) |-> (rsp_outer_gap_area == OUT_MAX))
      else $error("saturated status without saturated outer gap");

endmodule

// ----- tb/triangle_circle_areas_tb.sv -----
// Testbench for the triangle circle area pipeline: directed table, then random requests.
`timescale 1ns / 1ps
module triangle_circle_areas_tb;
   import tca_pkg::*;

   localparam int MAX_SIDE     = (1 << SIDE_W) - 1;
   localparam int PHASE_ITEMS  = 320;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_LIMIT  = 200000;

   typedef struct {
      logic [SIDE_W-1:0] a;
      logic [SIDE_W-1:0] b;
      logic [SIDE_W-1:0] c;
      bit                typed;   // expected result written out in the row
      tca_result_type    want;
   } side_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SIDE_W-1:0]   req_side_a;
   logic [SIDE_W-1:0]   req_side_b;
   logic [SIDE_W-1:0]   req_side_c;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [AREA_W-1:0]   rsp_outer_gap_area;
   logic [AREA_W-1:0]   rsp_inner_gap_area;
   logic [AREA_W-1:0]   rsp_incircle_area;
   logic [STATUS_W-1:0] rsp_status;

   // request-side sideband: a typed expectation travels with the request
   bit                  cur_typed;
   tca_result_type      cur_want;

   tca_result_type      pending_areas[$];
   side_row_type        directed_rows[$];

   int                  send_idle_pct;
   int                  stall_pct;
   bit                  hold_go;
   int                  hold_left;
   int                  mismatch_count;
   int                  unexpected_count;
   int                  accepted_count;
   int                  checked_count;
   int                  status_seen[4];

   triangle_circle_areas dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_side_a         (req_side_a),
      .req_side_b         (req_side_b),
      .req_side_c         (req_side_c),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outer_gap_area (rsp_outer_gap_area),
      .rsp_inner_gap_area (rsp_inner_gap_area),
      .rsp_incircle_area  (rsp_incircle_area),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the pipeline hangs.
   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Compute the expected areas with exact wide integers. Heron product
   // P = S*u*v*w stays under 2^104, pi times (abc)^2 under 2^210, so 256 bits
   // carry every intermediate without loss.
   function automatic tca_result_type predict_areas(logic [SIDE_W-1:0] a,
                                                    logic [SIDE_W-1:0] b,
                                                    logic [SIDE_W-1:0] c);
      tca_result_type res;
      longint         leg_u;
      longint         leg_v;
      longint         leg_w;
      logic [255:0]   perim;
      logic [255:0]   legs;
      logic [255:0]   heron;
      logic [255:0]   cand;
      logic [255:0]   root;
      logic [255:0]   tri_area;
      logic [255:0]   in_area;
      logic [255:0]   circ_area;
      logic [255:0]   abc;
      logic [255:0]   den;
      logic [255:0]   gap;
      res   = '0;
      leg_u = longint'(b) + longint'(c) - longint'(a);
      leg_v = longint'(a) + longint'(c) - longint'(b);
      leg_w = longint'(a) + longint'(b) - longint'(c);
      // zero side wins over the triangle test
      if (a == 0 || b == 0 || c == 0) begin
         res.status = ST_ZERO;
         return res;
      end
      if (leg_u <= 0 || leg_v <= 0 || leg_w <= 0) begin
         res.status = ST_BAD;
         return res;
      end
      perim = 256'(a) + 256'(b) + 256'(c);
      legs  = 256'(leg_u) * 256'(leg_v) * 256'(leg_w);
      heron = perim * legs;

      root = '0;
      for (int k = 52; k >= 0; k--) begin
         cand = root | (256'(1) << k);
         if (cand * cand <= heron) root = cand;
      end
      tri_area = (root + (256'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);

      // round to nearest, ties upward: (2n + d) / 2d
      den     = perim << (FRAC_BITS + 62);
      in_area = ((256'(PI60) * legs << 1) + den) / (den << 1);

      abc       = 256'(a) * 256'(b) * 256'(c);
      den       = heron << (FRAC_BITS + 60);
      circ_area = ((256'(PI60) * abc * abc << 1) + den) / (den << 1);

      res.status         = ST_OK;
      res.incircle_area  = in_area[AREA_W-1:0];
      res.inner_gap_area = (in_area <= tri_area) ? AREA_W'(tri_area - in_area) : '0;
      if (circ_area < tri_area) begin
         res.outer_gap_area = '0;
      end else begin
         gap = circ_area - tri_area;
         if (gap > 256'(OUT_MAX)) begin
            res.outer_gap_area = OUT_MAX;
            res.status         = ST_SAT;
         end else begin
            res.outer_gap_area = gap[AREA_W-1:0];
         end
      end
      return res;
   endfunction

   // Offer one request; hold it until taken. Inputs move only at the falling edge.
   task automatic offer_sides(logic [SIDE_W-1:0] a, logic [SIDE_W-1:0] b,
                              logic [SIDE_W-1:0] c, bit typed, tca_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_side_a = a;
      req_side_b = b;
      req_side_c = c;
      cur_typed  = typed;
      cur_want   = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Random sides: mostly well-formed triangles, the rest raw noise and zeros.
   task automatic offer_random;
      logic [SIDE_W-1:0] a;
      logic [SIDE_W-1:0] b;
      logic [SIDE_W-1:0] c;
      int                top;
      int                lo;
      int                hi;
      int                pick;
      pick = int'($urandom_range(99));
      if (pick < 15) begin
         a = SIDE_W'($urandom);
         b = SIDE_W'($urandom);
         c = SIDE_W'($urandom);
      end else if (pick < 20) begin
         a = SIDE_W'($urandom);
         b = SIDE_W'($urandom);
         c = SIDE_W'($urandom);
         case ($urandom_range(2))
            0: a = '0;
            1: b = '0;
            default: c = '0;
         endcase
      end else begin
         // pick a size scale so small, medium and huge triangles all occur
         top = int'($urandom_range(SIDE_W - 1, 1));
         a   = SIDE_W'($urandom_range((1 << top) - 1, 1));
         b   = SIDE_W'($urandom_range((1 << top) - 1, 1));
         lo  = (a > b) ? int'(a) - int'(b) + 1 : int'(b) - int'(a) + 1;
         hi  = int'(a) + int'(b) - 1;
         if (hi > MAX_SIDE) hi = MAX_SIDE;
         if (lo > hi) lo = hi;
         // push toward degenerate edges now and then to reach saturation
         case ($urandom_range(9))
            0: c = SIDE_W'(lo);
            1: c = SIDE_W'(hi);
            default: c = SIDE_W'($urandom_range(hi, lo));
         endcase
         if ($urandom_range(1)) {a, c} = {c, a};
      end
      offer_sides(a, b, c, 1'b0, '0);
   endtask

   task automatic add_row(int a, int b, int c, bit typed, logic [STATUS_W-1:0] st);
      side_row_type row;
      row.a     = SIDE_W'(a);
      row.b     = SIDE_W'(b);
      row.c     = SIDE_W'(c);
      row.typed = typed;
      row.want  = '0;
      row.want.status = st;
      directed_rows.push_back(row);
   endtask

   // Receiver: random stall, or one long hold-off counted down here once started.
   initial begin
      hold_left = HOLD_CYCLES;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall = ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Queue the expected areas for each request taken.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         accepted_count++;
         if (cur_typed) pending_areas.push_back(cur_want);
         else pending_areas.push_back(predict_areas(req_side_a, req_side_b, req_side_c));
      end
   end

   // Compare each response against the oldest expectation.
   always @(posedge clock) begin
      tca_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_areas.size() == 0) begin
            unexpected_count++;
            if (unexpected_count + mismatch_count <= 10)
               $display("unexpected response: status %0d", rsp_status);
         end else begin
            want = pending_areas.pop_front();
            checked_count++;
            status_seen[rsp_status]++;
            if (rsp_outer_gap_area !== want.outer_gap_area ||
                rsp_inner_gap_area !== want.inner_gap_area ||
                rsp_incircle_area  !== want.incircle_area  ||
                rsp_status         !== want.status) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= 10)
                  $display("mismatch #%0d: outer %h/%h inner %h/%h incircle %h/%h status %0d/%0d",
                           checked_count, rsp_outer_gap_area, want.outer_gap_area,
                           rsp_inner_gap_area, want.inner_gap_area,
                           rsp_incircle_area, want.incircle_area,
                           rsp_status, want.status);
            end
         end
      end
   end

   initial begin
      int guard;
      req_valid      = 1'b0;
      req_side_a     = '0;
      req_side_b     = '0;
      req_side_c     = '0;
      cur_typed      = 1'b0;
      cur_want       = '0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      hold_go        = 1'b0;

      // zero sides, checked before the triangle test
      add_row(0, 0, 0, 1, ST_ZERO);
      add_row(0, 256, 256, 1, ST_ZERO);
      add_row(MAX_SIDE, 0, MAX_SIDE, 1, ST_ZERO);
      add_row(MAX_SIDE, MAX_SIDE, 0, 1, ST_ZERO);
      // degenerate and impossible triangles
      add_row(1, 1, 2, 1, ST_BAD);
      add_row(MAX_SIDE, 1, 1, 1, ST_BAD);
      add_row(1, MAX_SIDE, 1, 1, ST_BAD);
      add_row(256, 512, 768, 1, ST_BAD);
      // ordinary and extreme triangles go through the predictor
      add_row(1, 1, 1, 0, ST_OK);
      add_row(768, 1024, 1280, 0, ST_OK);
      add_row(MAX_SIDE, MAX_SIDE, MAX_SIDE, 0, ST_OK);
      add_row(MAX_SIDE, MAX_SIDE, 1, 0, ST_OK);
      add_row(MAX_SIDE, 1, MAX_SIDE, 0, ST_OK);
      // slivers: huge circumcircle, first two saturate the outer gap; then a plain one
      add_row(1 << 23, (1 << 23) - 1, MAX_SIDE - 1, 0, ST_OK);
      add_row(MAX_SIDE - 1, 1 << 23, (1 << 23) - 1, 0, ST_OK);
      add_row(MAX_SIDE, MAX_SIDE - 1, 2, 0, ST_OK);
      add_row(12345, 54321, 60000, 0, ST_OK);

      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         offer_sides(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                     directed_rows[i].typed, directed_rows[i].want);

      // phase: no idling, with one long receiver hold-off to back up the pipeline
      hold_go = 1'b1;
      repeat (PHASE_ITEMS) offer_random();
      // phase: sender mostly idle
      send_idle_pct = 84;
      repeat (PHASE_ITEMS) offer_random();
      // phase: receiver mostly stalled
      send_idle_pct = 0;
      stall_pct     = 84;
      repeat (PHASE_ITEMS) offer_random();
      // phase: light idling on both sides
      send_idle_pct = 18;
      stall_pct     = 18;
      repeat (PHASE_ITEMS) offer_random();
      req_valid = 1'b0;

      // drain, then let any stray response show up
      guard = 0;
      while (pending_areas.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending_areas.size() != 0) begin
         $display("timeout: %0d responses outstanding", pending_areas.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         repeat (LATENCY + 20) @(posedge clock);
         $display("requests %0d, responses %0d: ok %0d, zero side %0d, bad %0d, saturated %0d",
                  accepted_count, checked_count, status_seen[ST_OK], status_seen[ST_ZERO],
                  status_seen[ST_BAD], status_seen[ST_SAT]);
         $display("mismatches %0d, unexpected responses %0d", mismatch_count,
                  unexpected_count);
         if (mismatch_count == 0 && unexpected_count == 0) begin
            $display("TB_OK");
         end else begin
            $display("TB_ERROR");
         end
         $finish;
      end
   end

endmodule

// ----- files.f -----
rtl/tca_pkg.sv
rtl/tca_mul.sv
rtl/tca_sqrt.sv
rtl/tca_div.sv
rtl/triangle_circle_areas.sv
tb/triangle_circle_areas_tb.sv
